// ===== rtl/fhm_pkg.sv =====
// Shared types and constants for the FIFO hand-off mutex.
// No dependencies; imported by every module of the block.
package fhm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // Port widths of the payload fields
  localparam int MODE_W   = 2;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 3;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [TID_W-1:0]    tid_port_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [ID_BITS-1:0]  tid_t;
  typedef logic [PTR_BITS-1:0] ptr_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  localparam mode_t MODE_TRY     = 2'd0;
  localparam mode_t MODE_WAIT    = 2'd1;
  localparam mode_t MODE_RELEASE = 2'd2;

  localparam status_t ST_ACQUIRED  = 3'd0;
  localparam status_t ST_BUSY      = 3'd1;
  localparam status_t ST_QUEUED    = 3'd2;
  localparam status_t ST_FREED     = 3'd3;
  localparam status_t ST_HANDED    = 3'd4;
  localparam status_t ST_NOT_OWNER = 3'd5;
  localparam status_t ST_FULL      = 3'd6;

  // Access to the wait-queue memory
  typedef struct packed {
    logic we;
    ptr_t waddr;
    tid_t wdata;
    ptr_t raddr;
  } ram_req_t;

  function automatic ptr_t ring_next(input ptr_t idx);
    ring_next = (idx == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(idx + 1'b1);
  endfunction

endpackage

// ===== rtl/fhm_wait_ram.sv =====
// Wait-queue storage: one write port, one registered read port.
// Depends on fhm_pkg.
module fhm_wait_ram (
  input  logic             clk,
  input  fhm_pkg::ram_req_t req,
  output fhm_pkg::tid_t     rd_data
);
  import fhm_pkg::*;

  tid_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

// ===== rtl/fhm_lock_ctrl.sv =====
// Lock state, ring pointers and request sequencer for the hand-off mutex.
// Depends on fhm_pkg; drives the fhm_wait_ram port.
module fhm_lock_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  fhm_pkg::mode_t       mode,
  input  fhm_pkg::tid_port_t   thread_id,
  output logic                 busy,
  input  fhm_pkg::tid_t        rd_data,
  output fhm_pkg::ram_req_t    ram_req,
  output logic                 done,
  output fhm_pkg::status_t     status,
  output fhm_pkg::tid_port_t   current_owner,
  output logic                 held
);
  import fhm_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic    state;
  mode_t   cmd_mode;
  tid_t    cmd_tid;
  logic    lock_held, lock_held_next;
  tid_t    owner_id, owner_id_next;
  ptr_t    head, head_next;
  ptr_t    tail, tail_next;
  cnt_t    count, count_next;
  status_t status_next;
  logic    push;

  assign busy = (state == S_EXEC);

  // Head is read every cycle; the read launched at accept lands in EXEC.
  assign ram_req.raddr = head;
  assign ram_req.waddr = tail;
  assign ram_req.wdata = cmd_tid;
  assign ram_req.we    = push;

  always_comb begin
    lock_held_next = lock_held;
    owner_id_next  = owner_id;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    push           = 1'b0;
    status_next    = ST_BUSY;
    if (state == S_EXEC) begin
      case (cmd_mode) inside
        MODE_TRY, MODE_WAIT: begin
          if (!lock_held) begin
            lock_held_next = 1'b1;
            owner_id_next  = cmd_tid;
            status_next    = ST_ACQUIRED;
          end else if (owner_id == cmd_tid) begin
            status_next = ST_ACQUIRED;
          end else if (cmd_mode == MODE_TRY) begin
            status_next = ST_BUSY;
          end else if (count == cnt_t'(QUEUE_DEPTH)) begin
            status_next = ST_FULL;
          end else begin
            push        = 1'b1;
            tail_next   = ring_next(tail);
            count_next  = cnt_t'(count + 1'b1);
            status_next = ST_QUEUED;
          end
        end
        MODE_RELEASE: begin
          if (!lock_held || owner_id != cmd_tid) begin
            status_next = ST_NOT_OWNER;
          end else if (count == '0) begin
            lock_held_next = 1'b0;
            owner_id_next  = '0;
            status_next    = ST_FREED;
          end else begin
            owner_id_next = rd_data;
            head_next     = ring_next(head);
            count_next    = cnt_t'(count - 1'b1);
            status_next   = ST_HANDED;
          end
        end
        default: status_next = ST_BUSY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lock_held <= 1'b0;
      owner_id  <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      done      <= 1'b0;
    end else begin
      lock_held <= lock_held_next;
      owner_id  <= owner_id_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      done      <= (state == S_EXEC);
      unique case (state)
        S_IDLE:  if (start) state <= S_EXEC;
        S_EXEC:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_mode <= mode;
      cmd_tid  <= thread_id[ID_BITS-1:0];
    end
    if (state == S_EXEC) begin
      status        <= status_next;
      held          <= lock_held_next;
      current_owner <= lock_held_next ? TID_W'(owner_id_next) : '0;
    end
  end

endmodule

// ===== rtl/fifo_handoff_mutex_unit.sv =====
// Top level of the FIFO hand-off mutex.
// Depends on fhm_pkg, fhm_lock_ctrl and fhm_wait_ram.

// A request is taken when start is high and busy is low. Each request reads
// the head of the wait-queue memory when it is accepted, then decides and
// writes back in the decide cycle. busy is high for the decide cycle, and
// done pulses for one cycle right after it with status, current_owner and
// held; the result is never held back, so the receiver must take it in that
// cycle. A new request may be presented while done is high.
// current_owner reads 0 whenever held is 0.
module fifo_handoff_mutex_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  fhm_pkg::mode_t      mode,
  input  fhm_pkg::tid_port_t  thread_id,
  output logic                done,
  output fhm_pkg::status_t    status,
  output fhm_pkg::tid_port_t  current_owner,
  output logic                held
);
  import fhm_pkg::*;

  ram_req_t ram_req;
  tid_t     rd_data;

  fhm_lock_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .mode          (mode),
    .thread_id     (thread_id),
    .busy          (busy),
    .rd_data       (rd_data),
    .ram_req       (ram_req),
    .done          (done),
    .status        (status),
    .current_owner (current_owner),
    .held          (held)
  );

  fhm_wait_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result strobe missing two cycles after accept");

  a_free_owner: assert property (@(posedge clk) disable iff (rst)
    (done && !held) |-> (current_owner == '0))
    else $error("owner nonzero while lock free");

  a_freed_state: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FREED) |-> !held)
    else $error("freed status with lock held");

  a_held_state: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_HANDED || status == ST_QUEUED || status == ST_ACQUIRED))
      |-> held)
    else $error("status implies lock held");

endmodule
